@@ rtl/scsd_pkg.sv @@
// ---------------------------------------------------------------------------
// scsd_pkg
// Shared codes, types and the entity text table of the serial command
// stream demultiplexer.
// ---------------------------------------------------------------------------
`default_nettype none

package scsd_pkg;

    localparam int SIZE_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 16;

    typedef logic [3:0] t_kind;
    typedef logic [2:0] t_phase;
    typedef logic [1:0] t_ent;
    typedef logic [2:0] t_idx;

    // result kinds
    localparam t_kind K_TEXT    = 4'd0;
    localparam t_kind K_FSTART  = 4'd1;
    localparam t_kind K_FDATA   = 4'd2;
    localparam t_kind K_FDONE   = 4'd3;
    localparam t_kind K_SHOT    = 4'd4;
    localparam t_kind K_ASTART  = 4'd5;
    localparam t_kind K_ASTOP   = 4'd6;
    localparam t_kind K_HOSTINT = 4'd7;
    localparam t_kind K_DONE    = 4'd8;

    // phases
    localparam t_phase PH_TEXT  = 3'd0;
    localparam t_phase PH_SIZE0 = 3'd1;
    localparam t_phase PH_SIZE1 = 3'd2;
    localparam t_phase PH_SIZE2 = 3'd3;
    localparam t_phase PH_DATA  = 3'd4;
    localparam t_phase PH_END   = 3'd6;

    // received command bytes
    localparam logic [7:0] C_ESC    = 8'h00;
    localparam logic [7:0] C_SHOT   = 8'h01;
    localparam logic [7:0] C_ASTART = 8'h02;
    localparam logic [7:0] C_ASTOP  = 8'h03;
    localparam logic [7:0] C_FILE   = 8'h04;
    localparam logic [7:0] C_HOST   = 8'h05;
    localparam logic [7:0] C_END    = 8'h1A;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_AMP    = 8'h26;

    // entity expansion selectors
    localparam t_ent ENT_NONE = 2'd0;
    localparam t_ent ENT_LT   = 2'd1;
    localparam t_ent ENT_AMP  = 2'd2;

    localparam t_idx LT_LEN  = 3'd4;
    localparam t_idx AMP_LEN = 3'd5;

    // character idx of "&lt;" or "&amp;"
    function automatic logic [7:0] ent_char(input t_ent ent, input t_idx idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (ent == ENT_LT) begin
            unique case (idx)
                3'd0:    ch = "&";
                3'd1:    ch = "l";
                3'd2:    ch = "t";
                default: ch = ";";
            endcase
        end else begin
            unique case (idx)
                3'd0:    ch = "&";
                3'd1:    ch = "a";
                3'd2:    ch = "m";
                3'd3:    ch = "p";
                default: ch = ";";
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/serial_command_stream_demux.sv @@
// ---------------------------------------------------------------------------
// serial_command_stream_demux
// Splits a byte stream from a target machine into text, file, screenshot,
// audio, host interrupt and job complete events.
// ---------------------------------------------------------------------------
// A byte is decoded in the cycle it is accepted and its results land in an
// output register; a new byte is taken every cycle while the output side
// keeps up. A byte that yields several results (the file start/done pair or
// an HTML entity for '<' or '&') holds the input while its results go out
// in turn. The input is taken in the same cycle the last result of the
// previous byte is accepted downstream.
`default_nettype none

module serial_command_stream_demux #(
    parameter int SIZE_BITS  = scsd_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = scsd_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_rx_byte,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [3:0]  o_kind,
    output      logic [7:0]  o_out_byte,
    output      logic [15:0] o_event_number,
    output      logic [23:0] o_file_length,
    output      logic        o_last
);
    import scsd_pkg::*;

    // decoder state
    logic                  r_lit,   n_lit;
    t_phase                r_phase, n_phase;
    logic [SIZE_BITS-1:0]  r_size,  n_size;
    logic [SIZE_BITS-1:0]  r_pos,   n_pos;
    logic                  r_rec,   n_rec;
    logic [COUNT_BITS-1:0] r_img,   n_img;
    logic [COUNT_BITS-1:0] r_aud,   n_aud;
    logic [COUNT_BITS-1:0] r_file,  n_file;

    // output register
    logic                  r_valid;
    t_idx                  r_idx;
    t_idx                  r_cnt,   n_cnt;
    t_ent                  r_ent,   n_ent;
    t_kind                 r_kind,  n_kind;
    logic [7:0]            r_byte,  n_byte;
    logic [COUNT_BITS-1:0] r_num,   n_num;
    logic [SIZE_BITS-1:0]  r_len,   n_len;

    logic accept;
    logic take;
    logic is_cmd;
    logic last;
    logic [31:0] size_wide;
    logic [SIZE_BITS-1:0] pos_inc;

    assign last    = (r_idx == r_cnt - 3'd1);
    assign o_ready = !r_valid || (i_ready && last);
    assign accept  = i_valid && o_ready;

    assign is_cmd = (i_rx_byte == C_ESC) || (i_rx_byte == C_SHOT) ||
                    (i_rx_byte == C_ASTART) || (i_rx_byte == C_ASTOP) ||
                    (i_rx_byte == C_FILE) || (i_rx_byte == C_HOST) ||
                    (i_rx_byte == C_END);
    assign take    = r_lit || !is_cmd;
    assign pos_inc = r_pos + SIZE_BITS'(1);

    always_comb begin
        n_lit   = r_lit;
        n_phase = r_phase;
        n_size  = r_size;
        n_pos   = r_pos;
        n_rec   = r_rec;
        n_img   = r_img;
        n_aud   = r_aud;
        n_file  = r_file;
        n_cnt   = 3'd0;
        n_ent   = ENT_NONE;
        n_kind  = K_TEXT;
        n_byte  = 8'h00;
        n_num   = '0;
        n_len   = '0;
        size_wide = '0;

        if (i_action) begin
            n_lit   = 1'b0;
            n_phase = PH_TEXT;
            n_size  = '0;
            n_pos   = '0;
            n_rec   = 1'b0;
            n_img   = '0;
            n_aud   = '0;
            n_file  = '0;
        end else if (r_phase != PH_END) begin
            n_lit = 1'b0;
            if (!take) begin
                unique case (i_rx_byte)
                    C_ESC: n_lit = 1'b1;
                    C_SHOT: begin
                        n_cnt  = 3'd1;
                        n_kind = K_SHOT;
                        n_num  = r_img;
                        n_img  = r_img + COUNT_BITS'(1);
                    end
                    C_ASTART: begin
                        n_rec  = 1'b1;
                        n_cnt  = 3'd1;
                        n_kind = K_ASTART;
                        n_num  = r_aud;
                    end
                    C_ASTOP: begin
                        if (r_rec) begin
                            n_cnt  = 3'd1;
                            n_kind = K_ASTOP;
                            n_num  = r_aud;
                            n_aud  = r_aud + COUNT_BITS'(1);
                            n_rec  = 1'b0;
                        end
                    end
                    C_FILE: n_phase = PH_SIZE0;
                    C_HOST: begin
                        n_cnt  = 3'd1;
                        n_kind = K_HOSTINT;
                    end
                    default: begin
                        // end of job
                        n_cnt   = 3'd1;
                        n_kind  = K_DONE;
                        n_phase = PH_END;
                    end
                endcase
            end else begin
                unique case (r_phase)
                    PH_TEXT: begin
                        n_kind = K_TEXT;
                        if (i_rx_byte == C_LT) begin
                            n_cnt = LT_LEN;
                            n_ent = ENT_LT;
                        end else if (i_rx_byte == C_AMP) begin
                            n_cnt = AMP_LEN;
                            n_ent = ENT_AMP;
                        end else begin
                            n_cnt  = 3'd1;
                            n_byte = i_rx_byte;
                        end
                    end
                    PH_SIZE0: begin
                        n_size  = SIZE_BITS'(i_rx_byte);
                        n_phase = PH_SIZE1;
                    end
                    PH_SIZE1: begin
                        size_wide = {8'h00, 24'(r_size)} | {16'h0000, i_rx_byte, 8'h00};
                        n_size    = SIZE_BITS'(size_wide);
                        n_phase   = PH_SIZE2;
                    end
                    PH_SIZE2: begin
                        size_wide = 32'(r_size) | {8'h00, i_rx_byte, 16'h0000};
                        n_size    = SIZE_BITS'(size_wide);
                        n_pos     = '0;
                        n_cnt     = 3'd1;
                        n_kind    = K_FSTART;
                        n_num     = r_file;
                        n_len     = n_size;
                        n_phase   = PH_DATA;
                        // empty file: done follows at once
                        if (n_size == '0) begin
                            n_cnt   = 3'd2;
                            n_file  = r_file + COUNT_BITS'(1);
                            n_phase = PH_TEXT;
                        end
                    end
                    PH_DATA: begin
                        n_pos  = pos_inc;
                        n_cnt  = 3'd1;
                        n_kind = K_FDATA;
                        n_byte = i_rx_byte;
                        n_num  = r_file;
                        n_len  = r_size;
                        if (pos_inc == r_size) begin
                            n_cnt   = 3'd2;
                            n_file  = r_file + COUNT_BITS'(1);
                            n_phase = PH_TEXT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit   <= 1'b0;
            r_phase <= PH_TEXT;
            r_size  <= '0;
            r_pos   <= '0;
            r_rec   <= 1'b0;
            r_img   <= '0;
            r_aud   <= '0;
            r_file  <= '0;
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
            r_cnt   <= 3'd0;
        end else if (accept) begin
            r_lit   <= n_lit;
            r_phase <= n_phase;
            r_size  <= n_size;
            r_pos   <= n_pos;
            r_rec   <= n_rec;
            r_img   <= n_img;
            r_aud   <= n_aud;
            r_file  <= n_file;
            r_valid <= (n_cnt != 3'd0);
            r_idx   <= 3'd0;
            r_cnt   <= n_cnt;
        end else if (r_valid && i_ready) begin
            // advance through a multi-result transaction, drop after the last
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent  <= n_ent;
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_num  <= n_num;
            r_len  <= n_len;
        end
    end

    always_comb begin
        o_valid = r_valid;
        o_last  = last;
        if (r_ent != ENT_NONE) begin
            o_kind         = K_TEXT;
            o_out_byte     = ent_char(r_ent, r_idx);
            o_event_number = 16'h0000;
            o_file_length  = 24'h000000;
        end else if (r_idx == 3'd0) begin
            o_kind         = r_kind;
            o_out_byte     = r_byte;
            o_event_number = 16'(r_num);
            o_file_length  = (r_kind == K_FDATA) ? 24'h000000 : 24'(r_len);
        end else begin
            o_kind         = K_FDONE;
            o_out_byte     = 8'h00;
            o_event_number = 16'(r_num);
            o_file_length  = 24'(r_len);
        end
    end

endmodule

`default_nettype wire

@@ rtl/scsd_checker.sv @@
// ---------------------------------------------------------------------------
// scsd_checker
// Port-level checks on the result stream of the demultiplexer.
// ---------------------------------------------------------------------------
`default_nettype none

module scsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_action,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [3:0]  o_kind,
    input wire logic [7:0]  o_out_byte,
    input wire logic [15:0] o_event_number,
    input wire logic [23:0] o_file_length,
    input wire logic        o_last
);
    import scsd_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_out_byte)
            && $stable(o_event_number) && $stable(o_file_length) && $stable(o_last))
        else $error("result changed while stalled");

    // file done always closes its input byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_FDONE |-> o_last)
        else $error("file done not last");

    // '<' never leaves unexpanded in text results
    a_no_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_TEXT |-> o_out_byte != C_LT)
        else $error("raw '<' in text");

    // only text and file data carry a byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_TEXT && o_kind != K_FDATA |-> o_out_byte == 8'h00)
        else $error("event carries a byte");

    // a job restart leaves nothing to report
    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_action |=> !o_valid)
        else $error("result after job restart");

endmodule

bind serial_command_stream_demux scsd_checker u_scsd_checker (.*);

`default_nettype wire
